// ----- src/epw_pkg.sv -----
package epw_pkg;

    typedef enum logic [2:0] {
        REG_POLL_INTERVAL     = 3'd0,
        REG_RESPONSE_DEADLINE = 3'd1,
        REG_RETRY_BACKOFF     = 3'd2,
        REG_SILENCE_WARN      = 3'd3,
        REG_RESTART_AFTER     = 3'd4,
        REG_FAILURE_AFTER     = 3'd5,
        REG_BUTTON_COUNT      = 3'd6,
        REG_PUBLISH_ENABLE    = 3'd7
    } epw_reg_t;

    localparam int ADDR_WIDTH = 5;
    localparam int DATA_WIDTH = 32;

    localparam logic [9:0]  POLL_INTERVAL_RST     = 10'd4;
    localparam logic [9:0]  RESPONSE_DEADLINE_RST = 10'd10;
    localparam logic [15:0] RETRY_BACKOFF_RST     = 16'd500;
    localparam logic [19:0] SILENCE_WARN_RST      = 20'd2000;
    localparam logic [19:0] RESTART_AFTER_RST     = 20'd3000;
    localparam logic [19:0] FAILURE_AFTER_RST     = 20'd20000;
    localparam logic [3:0]  BUTTON_COUNT_RST      = 4'd8;
    localparam logic        PUBLISH_ENABLE_RST    = 1'b0;
    localparam logic [3:0]  BUTTON_COUNT_MAX      = 4'd8;

    typedef struct packed {
        logic              send_poll;
        logic              send_restart;
        logic              silence_warning;
        logic              recovered;
        logic              fault;
        logic              fresh;
        logic [15:0]       trigger_magnitude;
        logic signed [15:0] velocity_out;
        logic [7:0]        buttons;
        logic              buttons_valid;
    } epw_result_t;

endpackage

// ----- src/epw_if.sv -----
interface epw_in_if;
    logic               valid;
    logic               ready;
    logic [9:0]         elapsed_ms;
    logic [15:0]        response_count;
    logic signed [15:0] position;
    logic signed [15:0] velocity;
    logic [7:0]         button_bits;

    modport source (
        output valid, elapsed_ms, response_count, position, velocity, button_bits,
        input  ready
    );
    modport sink (
        input  valid, elapsed_ms, response_count, position, velocity, button_bits,
        output ready
    );
endinterface

interface epw_out_if;
    logic               valid;
    logic               ready;
    logic               send_poll;
    logic               send_restart;
    logic               silence_warning;
    logic               recovered;
    logic               fault;
    logic               fresh;
    logic [15:0]        trigger_magnitude;
    logic signed [15:0] velocity_out;
    logic [7:0]         buttons;
    logic               buttons_valid;

    modport source (
        output valid, send_poll, send_restart, silence_warning, recovered, fault, fresh,
               trigger_magnitude, velocity_out, buttons, buttons_valid,
        input  ready
    );
    modport sink (
        input  valid, send_poll, send_restart, silence_warning, recovered, fault, fresh,
               trigger_magnitude, velocity_out, buttons, buttons_valid,
        output ready
    );
endinterface

// ----- src/encoder_poll_watchdog_core.sv -----
// Pipeline: a word accepted on req loads the input register, then the result register,
// which drives rsp; both registers hold their word while rsp is stalled.
// Throughput: one word per cycle while rsp is not stalled; one state update per word.
// Reset (rst_n, asynchronous, active low): clears the clock, watchdog state and
// pipeline valids, and returns all configuration registers to their defaults.
module encoder_poll_watchdog_core #(
    parameter int TIME_WIDTH  = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [epw_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [epw_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [epw_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                            pready,
    epw_in_if.sink                          req,
    epw_out_if.source                       rsp
);

    localparam int CNT_W = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;

    typedef logic [TIME_WIDTH-1:0] time_t;

    function automatic logic time_ge(input time_t a, input time_t b);
        time_t d;
        d = a - b;
        return !d[TIME_WIDTH-1];
    endfunction

    logic [9:0]  poll_interval_reg;
    logic [9:0]  response_deadline_reg;
    logic [15:0] retry_backoff_reg;
    logic [19:0] silence_warn_reg;
    logic [19:0] restart_after_reg;
    logic [19:0] failure_after_reg;
    logic [3:0]  button_count_reg;
    logic        publish_enable_reg;

    logic               s1_valid_reg;
    logic [9:0]         s1_elapsed_reg;
    logic [CNT_W-1:0]   s1_count_reg;
    logic [15:0]        s1_position_reg;
    logic [15:0]        s1_velocity_reg;
    logic [7:0]         s1_buttons_reg;

    time_t            clock_reg, clock_next;
    logic [CNT_W-1:0] last_count_reg;
    logic             seen_reg, seen_next;
    logic             pending_reg, pending_next;
    time_t            sent_time_reg, sent_time_next;
    time_t            next_poll_reg, next_poll_next;
    time_t            last_resp_reg, last_resp_next;
    logic             warned_reg, warned_next;
    logic             restarted_reg, restarted_next;

    logic                  out_valid_reg;
    epw_pkg::epw_result_t  result_reg, result_next;

    logic     s1_advance;
    logic     step;
    logic     cfg_write;
    epw_pkg::epw_reg_t cfg_index;

    assign s1_advance = !out_valid_reg || rsp.ready;
    assign req.ready  = !s1_valid_reg || s1_advance;
    assign step       = s1_valid_reg && s1_advance;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign cfg_index  = epw_pkg::epw_reg_t'(paddr[epw_pkg::ADDR_WIDTH-1:2]);
    assign pready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_interval_reg     <= epw_pkg::POLL_INTERVAL_RST;
            response_deadline_reg <= epw_pkg::RESPONSE_DEADLINE_RST;
            retry_backoff_reg     <= epw_pkg::RETRY_BACKOFF_RST;
            silence_warn_reg      <= epw_pkg::SILENCE_WARN_RST;
            restart_after_reg     <= epw_pkg::RESTART_AFTER_RST;
            failure_after_reg     <= epw_pkg::FAILURE_AFTER_RST;
            button_count_reg      <= epw_pkg::BUTTON_COUNT_RST;
            publish_enable_reg    <= epw_pkg::PUBLISH_ENABLE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                epw_pkg::REG_POLL_INTERVAL:     poll_interval_reg     <= pwdata[9:0];
                epw_pkg::REG_RESPONSE_DEADLINE: response_deadline_reg <= pwdata[9:0];
                epw_pkg::REG_RETRY_BACKOFF:     retry_backoff_reg     <= pwdata[15:0];
                epw_pkg::REG_SILENCE_WARN:      silence_warn_reg      <= pwdata[19:0];
                epw_pkg::REG_RESTART_AFTER:     restart_after_reg     <= pwdata[19:0];
                epw_pkg::REG_FAILURE_AFTER:     failure_after_reg     <= pwdata[19:0];
                epw_pkg::REG_BUTTON_COUNT:      button_count_reg      <= pwdata[3:0];
                epw_pkg::REG_PUBLISH_ENABLE:    publish_enable_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            epw_pkg::REG_POLL_INTERVAL:     prdata = 32'(poll_interval_reg);
            epw_pkg::REG_RESPONSE_DEADLINE: prdata = 32'(response_deadline_reg);
            epw_pkg::REG_RETRY_BACKOFF:     prdata = 32'(retry_backoff_reg);
            epw_pkg::REG_SILENCE_WARN:      prdata = 32'(silence_warn_reg);
            epw_pkg::REG_RESTART_AFTER:     prdata = 32'(restart_after_reg);
            epw_pkg::REG_FAILURE_AFTER:     prdata = 32'(failure_after_reg);
            epw_pkg::REG_BUTTON_COUNT:      prdata = 32'(button_count_reg);
            epw_pkg::REG_PUBLISH_ENABLE:    prdata = 32'(publish_enable_reg);
            default:                        prdata = '0;
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_elapsed_reg  <= req.elapsed_ms;
            s1_count_reg    <= req.response_count[CNT_W-1:0];
            s1_position_reg <= req.position;
            s1_velocity_reg <= req.velocity;
            s1_buttons_reg  <= req.button_bits;
        end
    end

    always_comb
    begin
        time_t      now;
        time_t      poll_due;
        time_t      silence;
        time_t      age;
        logic       fresh;
        logic       fault;
        logic [3:0] nb;
        logic [7:0] mask;

        now            = clock_reg + TIME_WIDTH'(s1_elapsed_reg);
        clock_next     = now;
        fresh          = (s1_count_reg != last_count_reg);
        fault          = 1'b0;
        seen_next      = seen_reg;
        pending_next   = pending_reg;
        sent_time_next = sent_time_reg;
        next_poll_next = next_poll_reg;
        last_resp_next = last_resp_reg;
        warned_next    = warned_reg;
        restarted_next = restarted_reg;
        poll_due       = sent_time_reg + TIME_WIDTH'(poll_interval_reg);
        silence        = now - last_resp_reg;
        age            = now - sent_time_reg;
        result_next    = '0;

        if (fresh)
        begin
            result_next.recovered = warned_reg || restarted_reg;
            seen_next      = 1'b1;
            pending_next   = 1'b0;
            last_resp_next = now;
            warned_next    = 1'b0;
            restarted_next = 1'b0;
            if (pending_reg && !time_ge(next_poll_reg, poll_due))
            begin
                next_poll_next = poll_due;
            end
        end
        else
        begin
            if (pending_reg && age >= TIME_WIDTH'(response_deadline_reg))
            begin
                pending_next   = 1'b0;
                next_poll_next = now + TIME_WIDTH'(retry_backoff_reg);
            end
            if (seen_reg)
            begin
                if (!warned_reg && silence >= TIME_WIDTH'(silence_warn_reg))
                begin
                    warned_next = 1'b1;
                    result_next.silence_warning = 1'b1;
                end
                if (!restarted_reg && silence >= TIME_WIDTH'(restart_after_reg))
                begin
                    restarted_next = 1'b1;
                    result_next.send_restart = 1'b1;
                    pending_next   = 1'b0;
                    next_poll_next = now + TIME_WIDTH'(retry_backoff_reg);
                end
                fault = (silence >= TIME_WIDTH'(failure_after_reg));
            end
        end

        if (!fault && !pending_next && time_ge(now, next_poll_next))
        begin
            result_next.send_poll = 1'b1;
            sent_time_next = now;
            pending_next   = 1'b1;
            next_poll_next = now + TIME_WIDTH'(poll_interval_reg);
        end

        nb   = (button_count_reg > epw_pkg::BUTTON_COUNT_MAX) ? epw_pkg::BUTTON_COUNT_MAX
                                                              : button_count_reg;
        mask = 8'((9'd1 << nb) - 9'd1);

        result_next.fault             = fault;
        result_next.fresh             = fresh;
        result_next.trigger_magnitude = s1_position_reg[15] ? 16'(~s1_position_reg + 16'd1)
                                                            : s1_position_reg;
        result_next.velocity_out      = s1_velocity_reg;
        result_next.buttons_valid     = fresh && publish_enable_reg && !fault;
        result_next.buttons           = result_next.buttons_valid ? (s1_buttons_reg & mask)
                                                                  : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg      <= '0;
            last_count_reg <= '0;
            seen_reg       <= 1'b0;
            pending_reg    <= 1'b0;
            sent_time_reg  <= '0;
            next_poll_reg  <= '0;
            last_resp_reg  <= '0;
            warned_reg     <= 1'b0;
            restarted_reg  <= 1'b0;
        end
        else if (step)
        begin
            clock_reg      <= clock_next;
            last_count_reg <= s1_count_reg;
            seen_reg       <= seen_next;
            pending_reg    <= pending_next;
            sent_time_reg  <= sent_time_next;
            next_poll_reg  <= next_poll_next;
            last_resp_reg  <= last_resp_next;
            warned_reg     <= warned_next;
            restarted_reg  <= restarted_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.send_poll         = result_reg.send_poll;
    assign rsp.send_restart      = result_reg.send_restart;
    assign rsp.silence_warning   = result_reg.silence_warning;
    assign rsp.recovered         = result_reg.recovered;
    assign rsp.fault             = result_reg.fault;
    assign rsp.fresh             = result_reg.fresh;
    assign rsp.trigger_magnitude = result_reg.trigger_magnitude;
    assign rsp.velocity_out      = result_reg.velocity_out;
    assign rsp.buttons           = result_reg.buttons;
    assign rsp.buttons_valid     = result_reg.buttons_valid;

endmodule

// ----- src/epw_checker.sv -----
module epw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        send_poll,
    input logic        recovered,
    input logic        fault,
    input logic        fresh,
    input logic [15:0] trigger_magnitude,
    input logic [7:0]  buttons,
    input logic        buttons_valid
);

    a_valid_needs_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && buttons_valid |-> fresh && !fault)
        else $error("buttons_valid without fresh report or under fault");

    a_buttons_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !buttons_valid |-> buttons == 8'd0)
        else $error("buttons nonzero while not valid");

    a_fault_blocks_poll: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && fault |-> !send_poll && !fresh)
        else $error("poll sent or fresh word under fault");

    a_recover_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && recovered |-> fresh)
        else $error("recovered without fresh report");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(trigger_magnitude)
        && $stable(send_poll))
        else $error("stalled result word changed");

endmodule

bind encoder_poll_watchdog_core epw_checker u_epw_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .send_poll         (rsp.send_poll),
    .recovered         (rsp.recovered),
    .fault             (rsp.fault),
    .fresh             (rsp.fresh),
    .trigger_magnitude (rsp.trigger_magnitude),
    .buttons           (rsp.buttons),
    .buttons_valid     (rsp.buttons_valid)
);

// ----- sim/tb_encoder_poll_watchdog_core.sv -----
module tb_encoder_poll_watchdog_core;

    typedef logic [31:0] ms_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [epw_pkg::ADDR_WIDTH-1:0] paddr;
    logic [epw_pkg::DATA_WIDTH-1:0] pwdata;
    logic [epw_pkg::DATA_WIDTH-1:0] prdata;
    logic                           pready;

    epw_in_if  req();
    epw_out_if rsp();

    encoder_poll_watchdog_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req),
        .rsp     (rsp)
    );

    logic [9:0]  cfg_interval;
    logic [9:0]  cfg_deadline;
    logic [15:0] cfg_backoff;
    logic [19:0] cfg_warn;
    logic [19:0] cfg_restart;
    logic [19:0] cfg_failure;
    logic [3:0]  cfg_buttons;
    logic        cfg_publish;

    ms_t         clock_now;
    ms_t         poll_time;
    ms_t         next_poll_at;
    ms_t         last_heard;
    logic [15:0] seen_count;
    logic        heard_any;
    logic        awaiting;
    logic        warned;
    logic        restarted;

    epw_pkg::epw_result_t results_due[$];
    int          mismatches;
    int          src_idle_pct;
    int          rsp_stall_pct;
    logic [15:0] last_count;

    always #10 clk = ~clk;

    function automatic logic at_or_after(input ms_t a, input ms_t b);
        ms_t d;
        d = a - b;
        return !d[31];
    endfunction

    function automatic epw_pkg::epw_result_t watchdog_step(input logic [9:0] el,
            input logic [15:0] cnt, input logic [15:0] pos, input logic [15:0] vel,
            input logic [7:0] btns);
        epw_pkg::epw_result_t r;
        ms_t         silence;
        ms_t         due;
        logic        was_waiting;
        logic [3:0]  nbtn;
        logic [8:0]  bmask;
        r = '0;
        clock_now = clock_now + ms_t'(el);
        r.fresh = (cnt != seen_count);
        seen_count = cnt;
        if (r.fresh)
        begin
            r.recovered = warned | restarted;
            was_waiting = awaiting;
            heard_any = 1'b1;
            awaiting = 1'b0;
            last_heard = clock_now;
            warned = 1'b0;
            restarted = 1'b0;
            if (was_waiting)
            begin
                due = poll_time + ms_t'(cfg_interval);
                if (!at_or_after(next_poll_at, due))
                    next_poll_at = due;
            end
        end
        else
        begin
            if (awaiting && (clock_now - poll_time) >= ms_t'(cfg_deadline))
            begin
                awaiting = 1'b0;
                next_poll_at = clock_now + ms_t'(cfg_backoff);
            end
            if (heard_any)
            begin
                silence = clock_now - last_heard;
                if (!warned && silence >= ms_t'(cfg_warn))
                begin
                    warned = 1'b1;
                    r.silence_warning = 1'b1;
                end
                if (!restarted && silence >= ms_t'(cfg_restart))
                begin
                    restarted = 1'b1;
                    r.send_restart = 1'b1;
                    awaiting = 1'b0;
                    next_poll_at = clock_now + ms_t'(cfg_backoff);
                end
                r.fault = (silence >= ms_t'(cfg_failure));
            end
        end
        if (!r.fault && !awaiting && at_or_after(clock_now, next_poll_at))
        begin
            r.send_poll = 1'b1;
            poll_time = clock_now;
            awaiting = 1'b1;
            next_poll_at = clock_now + ms_t'(cfg_interval);
        end
        r.trigger_magnitude = pos[15] ? 16'd0 - pos : pos;
        r.velocity_out = vel;
        r.buttons_valid = r.fresh & cfg_publish & ~r.fault;
        if (r.buttons_valid)
        begin
            nbtn = (cfg_buttons > epw_pkg::BUTTON_COUNT_MAX) ? epw_pkg::BUTTON_COUNT_MAX
                                                             : cfg_buttons;
            bmask = (9'd1 << nbtn) - 9'd1;
            r.buttons = btns & bmask[7:0];
        end
        return r;
    endfunction

    function automatic logic [9:0] rand_elapsed();
        return ($urandom_range(9) == 0) ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(0, 12));
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want,
            input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        epw_pkg::epw_result_t want;
        if (results_due.size() == 0)
        begin
            $error("result word with no expectation pending");
            mismatches++;
        end
        else
        begin
            want = results_due.pop_front();
            check_field("send_poll", want.send_poll, rsp.send_poll);
            check_field("send_restart", want.send_restart, rsp.send_restart);
            check_field("silence_warning", want.silence_warning, rsp.silence_warning);
            check_field("recovered", want.recovered, rsp.recovered);
            check_field("fault", want.fault, rsp.fault);
            check_field("fresh", want.fresh, rsp.fresh);
            check_field("trigger_magnitude", want.trigger_magnitude, rsp.trigger_magnitude);
            check_field("velocity_out", want.velocity_out, rsp.velocity_out);
            check_field("buttons", want.buttons, rsp.buttons);
            check_field("buttons_valid", want.buttons_valid, rsp.buttons_valid);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
                check_result();
            rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    task automatic send_word(input logic [9:0] el, input logic [15:0] cnt,
            input logic [15:0] pos, input logic [15:0] vel, input logic [7:0] btns);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid          <= 1'b1;
        req.elapsed_ms     <= el;
        req.response_count <= cnt;
        req.position       <= pos;
        req.velocity       <= vel;
        req.button_bits    <= btns;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        results_due.push_back(watchdog_step(el, cnt, pos, vel, btns));
        last_count = cnt;
    endtask

    task automatic send_call(input logic [9:0] el, input logic fresh_one);
        logic [15:0] cnt;
        cnt = fresh_one ? last_count + 16'd1 + 16'($urandom_range(0, 3)) : last_count;
        send_word(el, cnt, 16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input epw_pkg::epw_reg_t r, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            epw_pkg::REG_POLL_INTERVAL:     cfg_interval = value[9:0];
            epw_pkg::REG_RESPONSE_DEADLINE: cfg_deadline = value[9:0];
            epw_pkg::REG_RETRY_BACKOFF:     cfg_backoff  = value[15:0];
            epw_pkg::REG_SILENCE_WARN:      cfg_warn     = value[19:0];
            epw_pkg::REG_RESTART_AFTER:     cfg_restart  = value[19:0];
            epw_pkg::REG_FAILURE_AFTER:     cfg_failure  = value[19:0];
            epw_pkg::REG_BUTTON_COUNT:      cfg_buttons  = value[3:0];
            epw_pkg::REG_PUBLISH_ENABLE:    cfg_publish  = value[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] poll_iv, input logic [31:0] deadline_ms,
            input logic [31:0] backoff_ms, input logic [31:0] warn_ms,
            input logic [31:0] restart_ms, input logic [31:0] failure_ms,
            input logic [31:0] btn_count, input logic [31:0] publish);
        write_reg(epw_pkg::REG_POLL_INTERVAL, poll_iv);
        write_reg(epw_pkg::REG_RESPONSE_DEADLINE, deadline_ms);
        write_reg(epw_pkg::REG_RETRY_BACKOFF, backoff_ms);
        write_reg(epw_pkg::REG_SILENCE_WARN, warn_ms);
        write_reg(epw_pkg::REG_RESTART_AFTER, restart_ms);
        write_reg(epw_pkg::REG_FAILURE_AFTER, failure_ms);
        write_reg(epw_pkg::REG_BUTTON_COUNT, btn_count);
        write_reg(epw_pkg::REG_PUBLISH_ENABLE, publish);
    endtask

    task automatic test_first_call_and_extremes();
        send_word(10'd0, 16'h0000, 16'h0000, 16'h0000, 8'h00);
        send_word(10'd1023, 16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF);
        send_word(10'd0, 16'hFFFF, 16'h8000, 16'h7FFF, 8'h00);
        send_word(10'd3, 16'h0000, 16'hFFFF, 16'hFFFF, 8'hAA);
        send_word(10'd512, 16'h5555, 16'h0001, 16'h0000, 8'h55);
        send_word(10'd7, 16'h5555, 16'h8001, 16'h0001, 8'h0F);
    endtask

    task automatic test_button_masking();
        logic [3:0] counts[7] = '{4'd0, 4'd1, 4'd3, 4'd7, 4'd8, 4'd9, 4'd15};
        drain();
        write_reg(epw_pkg::REG_PUBLISH_ENABLE, {31'($urandom), 1'b1});
        foreach (counts[i])
        begin
            drain();
            write_reg(epw_pkg::REG_BUTTON_COUNT, {28'($urandom), counts[i]});
            send_word(10'd1, last_count + 16'd1, 16'($urandom), 16'($urandom), 8'hFF);
        end
        send_call(10'd1, 1'b0);
    endtask

    task automatic test_silence_ladder();
        drain();
        set_config(2, 3, 4, 5, 7, 10, 3, 1);
        send_call(10'd1, 1'b1);
        repeat (12) send_call(10'd1, 1'b0);
        send_call(10'd1, 1'b1);
        repeat (6) send_call(10'd2, 1'b0);
        send_call(10'd1, 1'b1);
    endtask

    task automatic test_zero_thresholds();
        drain();
        set_config(0, 0, 0, 0, 0, 0, 0, 0);
        send_call(10'd0, 1'b1);
        repeat (3) send_call(10'd0, 1'b0);
        repeat (2) send_call(10'd1, 1'b0);
        send_call(10'd0, 1'b1);
        send_call(10'd1, 1'b0);
    endtask

    task automatic test_long_silence();
        drain();
        set_config('1, '1, '1, '1, '1, '1, '1, '1);
        send_call(10'd1023, 1'b1);
        repeat (1030) send_call(10'd1023, 1'b0);
        send_call(10'd1023, 1'b1);
        repeat (2) send_call(10'd0, 1'b0);
    endtask

    task automatic run_random_phase(input int words);
        int          sent;
        int          run_len;
        logic [31:0] warn_at;
        logic [31:0] restart_at;
        sent = 0;
        drain();
        warn_at = $urandom_range(1, 250);
        restart_at = ($urandom_range(7) == 0) ? $urandom_range(0, warn_at)
                                               : warn_at + $urandom_range(0, 250);
        set_config($urandom_range(1, 24), $urandom_range(1, 40), $urandom_range(1, 150),
                   warn_at, restart_at, restart_at + $urandom_range(0, 600),
                   $urandom_range(0, 15), ($urandom_range(3) != 0));
        while (sent < words)
        begin
            case ($urandom_range(9))
                0:
                begin
                    send_word(rand_elapsed(), 16'($urandom), 16'($urandom), 16'($urandom),
                              8'($urandom));
                    sent++;
                end
                1, 2, 3:
                begin
                    run_len = $urandom_range(1, 4);
                    if (run_len > words - sent)
                        run_len = words - sent;
                    repeat (run_len) send_call(rand_elapsed(), 1'b1);
                    sent += run_len;
                end
                default:
                begin
                    run_len = ($urandom_range(3) == 0) ? $urandom_range(40, 150)
                                                        : $urandom_range(1, 40);
                    if (run_len > words - sent)
                        run_len = words - sent;
                    repeat (run_len) send_call(rand_elapsed(), 1'b0);
                    sent += run_len;
                end
            endcase
        end
    endtask

    task automatic test_random_traffic();
        for (int mode = 0; mode < 3; mode++)
        begin
            src_idle_pct  = (mode == 0) ? 21 : (mode == 1) ? 85 : 0;
            rsp_stall_pct = (mode == 0) ? 85 : (mode == 1) ? 21 : 0;
            repeat (4) run_random_phase(45);
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req.valid          = 1'b0;
        req.elapsed_ms     = '0;
        req.response_count = '0;
        req.position       = '0;
        req.velocity       = '0;
        req.button_bits    = '0;

        cfg_interval = epw_pkg::POLL_INTERVAL_RST;
        cfg_deadline = epw_pkg::RESPONSE_DEADLINE_RST;
        cfg_backoff  = epw_pkg::RETRY_BACKOFF_RST;
        cfg_warn     = epw_pkg::SILENCE_WARN_RST;
        cfg_restart  = epw_pkg::RESTART_AFTER_RST;
        cfg_failure  = epw_pkg::FAILURE_AFTER_RST;
        cfg_buttons  = epw_pkg::BUTTON_COUNT_RST;
        cfg_publish  = epw_pkg::PUBLISH_ENABLE_RST;
        clock_now    = '0;
        poll_time    = '0;
        next_poll_at = '0;
        last_heard   = '0;
        seen_count   = '0;
        heard_any    = 1'b0;
        awaiting     = 1'b0;
        warned       = 1'b0;
        restarted    = 1'b0;

        mismatches    = 0;
        last_count    = '0;
        src_idle_pct  = 21;
        rsp_stall_pct = 85;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_call_and_extremes();
        test_button_masking();
        test_silence_ladder();
        test_zero_thresholds();
        test_long_silence();
        test_random_traffic();
        drain();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
